// File: src/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and fixed constants of the character-cell text display:
// opcodes, transaction payloads and the layout of one stored cell.
// ----------------------------------------------------------------------------
package tcd_pkg;

  // Opcodes of the input channel.
  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_MOVE       = 3'd1;
  localparam logic [2:0] OP_COLOURS    = 3'd2;
  localparam logic [2:0] OP_LOAD_GLYPH = 3'd3;
  localparam logic [2:0] OP_READ_PIXEL = 3'd4;

  // Width of a screen coordinate on the input channel.
  localparam int PIX_W = 10;
  // Width that holds any screen size or grid span in pixels.
  localparam int EXT_W = 13;
  // Width that holds a linear cursor position before saturation.
  localparam int POS_W = 14;
  // Width that holds a glyph line number or the glyph height.
  localparam int GLINE_EXT_W = 6;

  // Colours after reset.
  localparam logic [3:0] RESET_FG = 4'd15;
  localparam logic [3:0] RESET_BG = 4'd0;

  // Payload of one input transaction.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [5:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [3:0]  fg_colour;
    logic [3:0]  bg_colour;
    logic [4:0]  glyph_line;
    logic [11:0] glyph_bits;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
  } in_item_t;

  // Payload of one result transaction.
  typedef struct packed {
    logic [3:0] pixel_colour;
    logic       in_text_area;
  } out_item_t;

  // One entry of the cell store.
  typedef struct packed {
    logic [7:0] code;
    logic [3:0] fg;
    logic [3:0] bg;
  } cell_t;

endpackage

// File: src/tcd_in_if.sv
// ----------------------------------------------------------------------------
// tcd_in_if
// Valid/ready channel that carries command transactions into the display.
// ----------------------------------------------------------------------------
interface tcd_in_if;
  logic              valid;
  logic              ready;
  tcd_pkg::in_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

// File: src/tcd_out_if.sv
// ----------------------------------------------------------------------------
// tcd_out_if
// Valid/ready channel that carries pixel read results out of the display.
// ----------------------------------------------------------------------------
interface tcd_out_if;
  logic               valid;
  logic               ready;
  tcd_pkg::out_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

// File: src/tcd_cdiv.sv
// ----------------------------------------------------------------------------
// tcd_cdiv
// Two-stage divider by a fixed divisor: a reciprocal multiply, then the
// remainder from the quotient. Exact for every dividend below 2**IN_W.
// ----------------------------------------------------------------------------
module tcd_cdiv #(
  parameter int DIVISOR = 12,
  parameter int IN_W    = 10,
  parameter int Q_W     = 6,
  parameter int R_W     = 4
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] din,
  output logic [Q_W-1:0]  quot,
  output logic [R_W-1:0]  rem
);
  import tcd_pkg::*;

  // With 2**SHIFT above din*DIVISOR the rounded-up reciprocal never lifts
  // the quotient past the next integer, so no correction step is needed.
  localparam int SHIFT   = IN_W + $clog2(DIVISOR);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / DIVISOR + 1);

  logic [PROD_W-1:0] prod_r;
  logic [IN_W-1:0]   num_r;
  logic [IN_W-1:0]   q_full;
  logic [IN_W-1:0]   r_full;
  logic [Q_W-1:0]    quot_r;
  logic [R_W-1:0]    rem_r;

  // First stage: multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(din) * PROD_W'(RECIP);
      num_r  <= din;
    end
  end

  // Second stage: quotient from the top bits, remainder by back-multiply.
  assign q_full = IN_W'(prod_r >> SHIFT);
  assign r_full = num_r - IN_W'(q_full * IN_W'(DIVISOR));

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= Q_W'(q_full);
      rem_r  <= R_W'(r_full);
    end
  end

  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// File: src/text_mode_cell_display.sv
// ----------------------------------------------------------------------------
// text_mode_cell_display
// Character-cell text display: cell store, write cursor, current colours,
// glyph store and a pixel read path for a video scan.
// ----------------------------------------------------------------------------
// The block takes one command transaction per clock while input ready is high,
// and returns a result only for a pixel read. Every command passes the same
// six-stage pipeline: input register, two stages that split the pixel position
// into cell and glyph coordinates by reciprocal multiply, the cell store stage
// (cursor, colours and cell writes happen here), the glyph store stage (glyph
// row loads happen here) and the result register. Each store has one write and
// one read port used once per command, which is what holds the rate at one
// command per clock. Input ready drops while the result register holds a result
// that has not been taken, and during the cell store clearing pass. After reset
// the cell store is cleared one cell per clock, all GRID_COLUMNS*GRID_ROWS cells
// (1000 by default), and no command is accepted until that pass ends. The
// glyph store is not cleared: load every glyph row a pixel read will touch.
// ----------------------------------------------------------------------------
module text_mode_cell_display #(
  parameter int GRID_COLUMNS  = 40,
  parameter int GRID_ROWS     = 25,
  parameter int GLYPH_WIDTH   = 12,
  parameter int GLYPH_HEIGHT  = 20,
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 600
) (
  input  logic      clk,
  input  logic      rst_n,
  tcd_in_if.sink    in_ch,
  tcd_out_if.source out_ch
);
  import tcd_pkg::*;

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int GLYPH_ROWS = 256 * GLYPH_HEIGHT;
  localparam int GRID_PIX_W = GRID_COLUMNS * GLYPH_WIDTH;
  localparam int GRID_PIX_H = GRID_ROWS * GLYPH_HEIGHT;
  localparam int ORIGIN_X   = (SCREEN_WIDTH >= GRID_PIX_W) ?
                              (SCREEN_WIDTH - GRID_PIX_W) / 2 : 0;
  localparam int ORIGIN_Y   = (SCREEN_HEIGHT >= GRID_PIX_H) ?
                              (SCREEN_HEIGHT - GRID_PIX_H) / 2 : 0;
  localparam int CA_W       = $clog2(CELL_COUNT + 1);
  localparam int CIDX_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int GIDX_W     = $clog2(GLYPH_ROWS);
  localparam int COL_W      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int BIT_W      = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int LINE_W     = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  // Pipeline advance: everything moves unless a result waits at the output.
  logic en;
  logic out_valid_r;
  out_item_t out_item_r;

  // Cell store clearing pass after reset.
  logic              clr_done_r;
  logic [CIDX_W-1:0] clr_cnt_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && clr_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == CIDX_W'(CELL_COUNT - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: input register.
  // ------------------------------------------------------------------
  logic     v0_r;
  in_item_t item0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0_r <= in_ch.item;
    end
  end

  // Stage A logic: text area test, grid-relative position, cursor target.
  logic [EXT_W-1:0] x_ext;
  logic [EXT_W-1:0] y_ext;
  logic             inside_a;
  logic [PIX_W-1:0] rx_a;
  logic [PIX_W-1:0] ry_a;
  logic [POS_W-1:0] pos_a;
  logic [CA_W-1:0]  cur_a;
  logic             gwr_a;

  assign x_ext    = EXT_W'(item0_r.pixel_x);
  assign y_ext    = EXT_W'(item0_r.pixel_y);
  assign inside_a = (x_ext < EXT_W'(SCREEN_WIDTH)) && (y_ext < EXT_W'(SCREEN_HEIGHT)) &&
                    (x_ext >= EXT_W'(ORIGIN_X)) && (y_ext >= EXT_W'(ORIGIN_Y)) &&
                    ((x_ext - EXT_W'(ORIGIN_X)) < EXT_W'(GRID_PIX_W)) &&
                    ((y_ext - EXT_W'(ORIGIN_Y)) < EXT_W'(GRID_PIX_H));
  assign rx_a     = PIX_W'(x_ext - EXT_W'(ORIGIN_X));
  assign ry_a     = PIX_W'(y_ext - EXT_W'(ORIGIN_Y));

  // A column past the grid wraps into later rows; past the end saturates.
  assign pos_a = POS_W'(item0_r.cursor_row) * POS_W'(GRID_COLUMNS) +
                 POS_W'(item0_r.cursor_col);
  assign cur_a = (pos_a > POS_W'(CELL_COUNT)) ? CA_W'(CELL_COUNT) : CA_W'(pos_a);

  // Glyph line numbers beyond the glyph height are dropped.
  assign gwr_a = GLINE_EXT_W'(item0_r.glyph_line) < GLINE_EXT_W'(GLYPH_HEIGHT);

  // ------------------------------------------------------------------
  // Stages 1 and 2: pixel position to cell column/row and glyph bit/line.
  // ------------------------------------------------------------------
  logic [COL_W-1:0]  col2;
  logic [BIT_W-1:0]  remx2;
  logic [ROW_W-1:0]  row2;
  logic [LINE_W-1:0] line2;

  tcd_cdiv #(
    .DIVISOR (GLYPH_WIDTH),
    .IN_W    (PIX_W),
    .Q_W     (COL_W),
    .R_W     (BIT_W)
  ) u_div_x (
    .clk  (clk),
    .en   (en),
    .din  (rx_a),
    .quot (col2),
    .rem  (remx2)
  );

  tcd_cdiv #(
    .DIVISOR (GLYPH_HEIGHT),
    .IN_W    (PIX_W),
    .Q_W     (ROW_W),
    .R_W     (LINE_W)
  ) u_div_y (
    .clk  (clk),
    .en   (en),
    .din  (ry_a),
    .quot (row2),
    .rem  (line2)
  );

  // Command fields travel alongside the divider stages.
  logic                   v1_r, v2_r;
  logic [2:0]             op1_r, op2_r;
  logic [7:0]             code1_r, code2_r;
  logic [CA_W-1:0]        cur1_r, cur2_r;
  logic [3:0]             fg1_r, fg2_r;
  logic [3:0]             bg1_r, bg2_r;
  logic                   gwr1_r, gwr2_r;
  logic [LINE_W-1:0]      gline1_r, gline2_r;
  logic [GLYPH_WIDTH-1:0] gbits1_r, gbits2_r;
  logic                   inside1_r, inside2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= item0_r.opcode;
      code1_r   <= item0_r.char_code;
      cur1_r    <= cur_a;
      fg1_r     <= item0_r.fg_colour;
      bg1_r     <= item0_r.bg_colour;
      gwr1_r    <= gwr_a;
      gline1_r  <= LINE_W'(item0_r.glyph_line);
      gbits1_r  <= GLYPH_WIDTH'(item0_r.glyph_bits);
      inside1_r <= inside_a;
      op2_r     <= op1_r;
      code2_r   <= code1_r;
      cur2_r    <= cur1_r;
      fg2_r     <= fg1_r;
      bg2_r     <= bg1_r;
      gwr2_r    <= gwr1_r;
      gline2_r  <= gline1_r;
      gbits2_r  <= gbits1_r;
      inside2_r <= inside1_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage C: cursor, colours and the cell store.
  // ------------------------------------------------------------------
  logic [CA_W-1:0]   cursor_r, cursor_nxt;
  logic [3:0]        fg_r, fg_nxt;
  logic [3:0]        bg_r, bg_nxt;
  logic              put_we;
  logic [CIDX_W-1:0] cell_raddr;
  cell_t             cell_mem [CELL_COUNT];
  cell_t             cell_rd_r;

  always_comb begin
    cursor_nxt = cursor_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    put_we     = 1'b0;
    if (en && v2_r) begin
      case (op2_r)
        OP_PUT_CHAR: begin
          if (cursor_r < CA_W'(CELL_COUNT)) begin
            put_we     = 1'b1;
            cursor_nxt = cursor_r + 1'b1;
          end
        end
        OP_MOVE: begin
          cursor_nxt = cur2_r;
        end
        OP_COLOURS: begin
          fg_nxt = fg2_r;
          bg_nxt = bg2_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      fg_r     <= RESET_FG;
      bg_r     <= RESET_BG;
    end else begin
      cursor_r <= cursor_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
    end
  end

  // Cell address of the pixel; only meaningful inside the text area.
  assign cell_raddr = CIDX_W'(int'(row2) * GRID_COLUMNS + int'(col2));

  always_ff @(posedge clk) begin
    if (!clr_done_r) begin
      cell_mem[clr_cnt_r] <= '0;
    end else if (put_we) begin
      cell_mem[cursor_r[CIDX_W-1:0]] <= '{code: code2_r, fg: fg_r, bg: bg_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  logic                   v3_r;
  logic [2:0]             op3_r;
  logic [7:0]             code3_r;
  logic                   gwr3_r;
  logic [LINE_W-1:0]      gline3_r;
  logic [GLYPH_WIDTH-1:0] gbits3_r;
  logic [LINE_W-1:0]      line3_r;
  logic [BIT_W-1:0]       bit3_r;
  logic                   inside3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  // Bit GLYPH_WIDTH-1 is the leftmost pixel of a glyph row.
  always_ff @(posedge clk) begin
    if (en) begin
      op3_r     <= op2_r;
      code3_r   <= code2_r;
      gwr3_r    <= gwr2_r;
      gline3_r  <= gline2_r;
      gbits3_r  <= gbits2_r;
      line3_r   <= line2;
      bit3_r    <= BIT_W'(GLYPH_WIDTH - 1) - remx2;
      inside3_r <= inside2_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage D: the glyph store.
  // ------------------------------------------------------------------
  logic                   glyph_we;
  logic [GIDX_W-1:0]      glyph_waddr;
  logic [GIDX_W-1:0]      glyph_raddr;
  logic [GLYPH_WIDTH-1:0] glyph_mem [GLYPH_ROWS];
  logic [GLYPH_WIDTH-1:0] glyph_rd_r;

  assign glyph_we    = en && v3_r && (op3_r == OP_LOAD_GLYPH) && gwr3_r;
  assign glyph_waddr = GIDX_W'(int'(code3_r) * GLYPH_HEIGHT + int'(gline3_r));
  assign glyph_raddr = GIDX_W'(int'(cell_rd_r.code) * GLYPH_HEIGHT + int'(line3_r));

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= gbits3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      glyph_rd_r <= glyph_mem[glyph_raddr];
    end
  end

  logic             rd4_r;
  logic             inside4_r;
  logic [BIT_W-1:0] bit4_r;
  logic [3:0]       fg4_r;
  logic [3:0]       bg4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd4_r <= 1'b0;
    end else if (en) begin
      rd4_r <= v3_r && (op3_r == OP_READ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside4_r <= inside3_r;
      bit4_r    <= bit3_r;
      fg4_r     <= cell_rd_r.fg;
      bg4_r     <= cell_rd_r.bg;
    end
  end

  // ------------------------------------------------------------------
  // Stage E: pixel colour into the result register.
  // ------------------------------------------------------------------
  logic [3:0] colour_e;

  assign colour_e = !inside4_r ? 4'd0 : (glyph_rd_r[bit4_r] ? fg4_r : bg4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rd4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.pixel_colour <= colour_e;
      out_item_r.in_text_area <= inside4_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------

  // The cursor never passes the end position.
  assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CA_W'(CELL_COUNT))
    else $error("write cursor beyond end of grid");

  // A character write below the end advances the cursor by exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (en && v2_r && op2_r == OP_PUT_CHAR && cursor_r < CA_W'(CELL_COUNT))
    |=> cursor_r == $past(cursor_r) + 1'b1)
    else $error("cursor did not advance after a character write");

  // No transaction is in flight while the cell store is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !(v0_r || v1_r || v2_r || v3_r || rd4_r || out_valid_r))
    else $error("transaction in flight during cell store clear");

  // A new result comes only from a pixel read leaving the glyph stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(rd4_r))
    else $error("result without a pixel read");

  // Pixels outside the text area are always colour zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.in_text_area) |-> out_item_r.pixel_colour == 4'd0)
    else $error("nonzero colour outside the text area");

endmodule
